// ===== sv/mfb_pkg.sv =====
// Package for the monochrome framebuffer pixel read-modify-write block.
// Holds geometry constants, field widths and action and register codes.
// Depends on nothing.
package mfb_pkg;

    localparam int RAM_DEPTH       = 32768;
    localparam int BYTES_PER_LINE  = 40;
    localparam int SCREEN_OFFSET   = 9600;
    localparam int LAST_ROW        = 239;

    localparam int ADDR_W          = $clog2(RAM_DEPTH);
    localparam int BYTE_W          = 8;
    localparam int PIXELS_PER_LINE = BYTES_PER_LINE * 8;

    localparam int ACTION_W        = 3;
    localparam int COORD_W         = 9;
    localparam int BYTE_ADDR_W     = 15;
    localparam int BIT_W           = 3;
    localparam int COL_W           = COORD_W - BIT_W;
    localparam int LINE_W          = $clog2(LAST_ROW + 1);
    localparam int CMP_W           = 12;

    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 1;

    localparam logic [ACTION_W-1:0] ACT_CLEAR_PIXEL = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SET_PIXEL   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_READ_PIXEL  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WRITE_BYTE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ_BYTE   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_SELECT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION   = 1'd1;

endpackage

// ===== sv/mfb_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and held while the read enable is low.
// Depends on nothing.
module mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/mono_framebuffer_pixel_rmw.sv =====
// Monochrome framebuffer pixel read-modify-write block, top level; uses mfb_pkg and mfb_ram.
// Each item passes accept and address mapping, RAM read, then modify and write back.
// The single read-modify-write sequencer takes no new item until the last one is done.
// Write back waits for a free output register; the result is then loaded there and waits.
// After reset the display RAM is cleared one byte a cycle, all 32768 bytes, with no item taken.
module mono_framebuffer_pixel_rmw (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mfb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mfb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [mfb_pkg::ACTION_W-1:0]      i_action,
    input  logic [mfb_pkg::COORD_W-1:0]       i_x,
    input  logic [mfb_pkg::COORD_W-1:0]       i_y,
    input  logic [mfb_pkg::BYTE_ADDR_W-1:0]   i_byte_address,
    input  logic [mfb_pkg::BYTE_W-1:0]        i_byte_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_pixel_value,
    output logic [mfb_pkg::BYTE_W-1:0]        o_read_value,
    output logic                              o_error
);
    import mfb_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_WRITE} t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic                r_screen_select;
    logic                r_orientation;

    logic [ACTION_W-1:0] r_action;
    logic [ADDR_W-1:0]   r_addr;
    logic [BIT_W-1:0]    r_bit;
    logic [BYTE_W-1:0]   r_data;
    logic                r_err;

    logic                r_out_valid;
    logic                r_pix;
    logic [BYTE_W-1:0]   r_rd;
    logic                r_oerr;

    logic [ADDR_W-1:0]   n_addr;
    logic [BIT_W-1:0]    n_bit;
    logic                n_err;
    logic [COL_W-1:0]    col;
    logic [LINE_W-1:0]   line;
    logic [ADDR_W-1:0]   base;

    logic [BYTE_W-1:0]   ram_q;
    logic [BYTE_W-1:0]   mask;
    logic [BYTE_W-1:0]   mod_data;
    logic                mod_wr;
    logic                n_pix;
    logic [BYTE_W-1:0]   n_rd;

    logic                in_accept;
    logic                can_load;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign can_load   = !r_out_valid || i_out_ready;
    assign base       = r_screen_select ? ADDR_W'(SCREEN_OFFSET) : '0;

    always_comb begin
        if (!r_orientation) begin
            n_err = (CMP_W'(i_x) >= CMP_W'(PIXELS_PER_LINE))
                 || (CMP_W'(i_y) > CMP_W'(LAST_ROW));
            col   = i_x[COORD_W-1:BIT_W];
            n_bit = i_x[BIT_W-1:0];
            line  = LINE_W'(i_y);
        end else begin
            n_err = (CMP_W'(i_x) > CMP_W'(LAST_ROW))
                 || (CMP_W'(i_y) >= CMP_W'(PIXELS_PER_LINE));
            col   = i_y[COORD_W-1:BIT_W];
            n_bit = i_y[BIT_W-1:0];
            line  = LINE_W'(CMP_W'(LAST_ROW) - CMP_W'(i_x));
        end
        n_addr = base + ADDR_W'(col) + ADDR_W'(line) * ADDR_W'(BYTES_PER_LINE);
        case (i_action)
            ACT_CLEAR_PIXEL, ACT_SET_PIXEL, ACT_READ_PIXEL: begin
            end
            ACT_WRITE_BYTE, ACT_READ_BYTE: begin
                n_addr = ADDR_W'(i_byte_address);
                n_err  = 1'b0;
            end
            default: begin
                n_err = 1'b0;
            end
        endcase
    end

    always_comb begin
        mask     = 8'h80 >> r_bit;
        mod_data = '0;
        mod_wr   = 1'b0;
        n_pix    = 1'b0;
        n_rd     = '0;
        if (!r_err) begin
            case (r_action)
                ACT_CLEAR_PIXEL: begin
                    mod_data = ram_q & ~mask;
                    mod_wr   = 1'b1;
                end
                ACT_SET_PIXEL: begin
                    mod_data = ram_q | mask;
                    mod_wr   = 1'b1;
                end
                ACT_READ_PIXEL: begin
                    n_pix = |(ram_q & mask);
                end
                ACT_WRITE_BYTE: begin
                    mod_data = r_data;
                    mod_wr   = 1'b1;
                end
                ACT_READ_BYTE: begin
                    n_rd = ram_q;
                end
                default: begin
                end
            endcase
        end
    end

    assign ram_we    = (r_state == S_CLEAR) || ((r_state == S_WRITE) && can_load && mod_wr);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : mod_data;

    mfb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (r_state == S_READ),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action <= i_action;
            r_addr   <= n_addr;
            r_bit    <= n_bit;
            r_data   <= i_byte_data;
            r_err    <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr_addr      <= '0;
            r_screen_select <= 1'b0;
            r_orientation   <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SCREEN_SELECT: r_screen_select <= i_cfg_data[0];
                    CFG_ORIENTATION:   r_orientation   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == S_WRITE) && can_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (can_load) begin
                        r_pix       <= n_pix;
                        r_rd        <= n_rd;
                        r_oerr      <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_value = r_pix;
    assign o_read_value  = r_rd;
    assign o_error       = r_oerr;

`ifndef SYNTHESIS
    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_READ))
        else $error("accepted beat did not start a RAM read");

    a_no_write_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state == S_WRITE)) |-> (!r_err && (r_action == ACT_CLEAR_PIXEL
            || r_action == ACT_SET_PIXEL || r_action == ACT_WRITE_BYTE)))
        else $error("RAM written by an item that must not change it");

    a_result_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WRITE) && can_load) |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("result beat not loaded after the write-back cycle");
`endif

endmodule
